FILE: rtl/core/droptail_queue_timing_model_macros.svh
// assertion macros shared by the queue timing model rtl
`ifndef DROPTAIL_QUEUE_TIMING_MODEL_MACROS_SVH
`define DROPTAIL_QUEUE_TIMING_MODEL_MACROS_SVH

// condition holds at every clock edge outside reset
`define DTQ_ASSERT_HOLDS(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("dtq check failed");

// same-cycle implication
`define DTQ_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dtq check failed");

// next-cycle implication
`define DTQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dtq check failed");

`endif

FILE: rtl/core/dtq_pkg.sv
// shared types and constants of the drop-tail queue timing model
`timescale 1ns / 1ps
package dtq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TIME_WIDTH_DEF  = 48;

    localparam int GAP_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int LIMIT_W   = 7;
    localparam int CNT32_W   = 32;
    localparam int SUM_W     = 60;
    localparam int OUT_T_W   = 48;
    localparam int OCC_W     = 7;

    // result tdata: occupancy, queue delay, departure, delivered, dropped,
    // peak, queue delay sum, end-to-end sum, padded to whole bytes
    localparam int OUT_PACK_W  = OCC_W + 2 * OUT_T_W + 2 * CNT32_W + OCC_W + 2 * SUM_W;
    localparam int OUT_TDATA_W = ((OUT_PACK_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_DELAY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 2'd3;

    typedef enum logic [1:0] {
        ALU_ADD_TIME = 2'd0,   // add, saturate at the time ceiling
        ALU_ADD_SUM  = 2'd1,   // add, saturate at the sum ceiling
        ALU_SUB      = 2'd2    // subtract, report borrow
    } t_alu_op;

endpackage

FILE: rtl/core/dtq_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module dtq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/dtq_alu.sv
// shared saturating add / subtract unit
`timescale 1ns / 1ps
module dtq_alu #(
    parameter int TW = 48,
    parameter int UW = 60
) (
    input  dtq_pkg::t_alu_op i_op,
    input  logic [UW-1:0]    i_a,
    input  logic [UW-1:0]    i_b,
    output logic [UW-1:0]    o_result,
    output logic             o_borrow
);
    import dtq_pkg::*;

    localparam logic [UW:0] TIME_CAP = {{(UW + 1 - TW){1'b0}}, {TW{1'b1}}};
    localparam logic [UW:0] SUM_CAP  = {{(UW + 1 - SUM_W){1'b0}}, {SUM_W{1'b1}}};

    logic [UW:0] w_sum;
    logic [UW:0] w_diff;
    logic [UW:0] w_cap;

    assign w_sum  = {1'b0, i_a} + {1'b0, i_b};
    assign w_diff = {1'b0, i_a} - {1'b0, i_b};
    assign w_cap  = (i_op == ALU_ADD_TIME) ? TIME_CAP : SUM_CAP;

    always_comb begin
        o_borrow = 1'b0;
        case (i_op)
            ALU_ADD_TIME, ALU_ADD_SUM: begin
                o_result = (w_sum > w_cap) ? w_cap[UW-1:0] : w_sum[UW-1:0];
            end
            ALU_SUB: begin
                o_result = w_diff[UW-1:0];
                o_borrow = w_diff[UW];
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/droptail_queue_timing_model.sv
// Drop-tail queue timing model. Each input transaction carries a packet's
// inter-arrival gap (tdata) and a start-of-run flag (tuser); each produces one
// result transaction with the drop flag (tuser) and the packet's occupancy,
// queueing delay, departure time and the run statistics (tdata). All
// arithmetic goes through one shared saturating add/subtract unit, stepped by
// a small sequencer. A packet is stepped through arrival, router arrival, one
// retirement step per departure it retires (each one compare in the shared
// unit against the head entry of the departure ring memory), the occupancy
// check and, when queued, departure and the sums. The next accept also waits
// while the previous result still waits on m_axis_tready. The ring needs no
// clearing pass. Configuration must be written only while the block is idle.
`timescale 1ns / 1ps
module droptail_queue_timing_model #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = dtq_pkg::TIME_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [dtq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dtq_pkg::CFG_W-1:0]        i_cfg_data,
    // packet input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dtq_pkg::GAP_W-1:0]        s_axis_tdata,   // arrival_gap
    input  logic [0:0]                       s_axis_tuser,   // start_run
    // result output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // occupancy_seen, queue_delay, depart_time, delivered_total,
    // dropped_total, peak_occupancy, queue_delay_sum, end_to_end_sum, zero pad
    output logic [dtq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [0:0]                       m_axis_tuser    // was_dropped
);
    import dtq_pkg::*;

`include "droptail_queue_timing_model_macros.svh"

    localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int TSW = CW + 1;
    localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int TW  = TIME_WIDTH;
    localparam int UW  = (TW > SUM_W) ? TW : SUM_W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_ARR  = 12'b0000_0000_0010,
        S_RA   = 12'b0000_0000_0100,
        S_RET  = 12'b0000_0000_1000,
        S_OCC  = 12'b0000_0001_0000,
        S_DEP  = 12'b0000_0010_0000,
        S_WS   = 12'b0000_0100_0000,
        S_E1   = 12'b0000_1000_0000,
        S_E2   = 12'b0001_0000_0000,
        S_E3   = 12'b0010_0000_0000,
        S_E4   = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } t_state;

    // configuration
    logic [CFG_W-1:0]   r_source_delay;
    logic [CFG_W-1:0]   r_service_time;
    logic [CFG_W-1:0]   r_sink_delay;
    logic [LIMIT_W-1:0] r_queue_limit;

    // run state
    t_state             r_state, n_state;
    logic [GAP_W-1:0]   r_gap, n_gap;
    logic [TW-1:0]      r_arr, n_arr;
    logic [TW-1:0]      r_ra, n_ra;
    logic [TW-1:0]      r_lastdep, n_lastdep;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [CNT32_W-1:0] r_acc, n_acc;
    logic [CNT32_W-1:0] r_disc, n_disc;
    logic [CW-1:0]      r_peak, n_peak;
    logic [SUM_W-1:0]   r_wsum, n_wsum;
    logic [SUM_W-1:0]   r_tsum, n_tsum;
    logic [SUM_W-1:0]   r_e2e, n_e2e;
    logic [TW-1:0]      r_qdelay, n_qdelay;
    logic [TW-1:0]      r_depart, n_depart;
    logic               r_dropped, n_dropped;
    logic [CW-1:0]      r_occ, n_occ;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                   r_out_drop, n_out_drop;

    // shared unit and ring
    t_alu_op            w_op;
    logic [UW-1:0]      w_a, w_b, w_res;
    logic               w_borrow;
    logic               w_retire;
    logic               w_ram_we;
    logic [AW-1:0]      w_waddr;
    logic [TSW-1:0]     w_tail_sum;
    logic [TW-1:0]      w_rdata;
    logic [LW-1:0]      w_limit;
    logic [OUT_PACK_W-1:0] w_pack;

    dtq_alu #(.TW(TW), .UW(UW)) u_alu (
        .i_op     (w_op),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_result (w_res),
        .o_borrow (w_borrow)
    );

    dtq_ram #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_res[TW-1:0]),
        .i_raddr (n_head),
        .o_rdata (w_rdata)
    );

    assign w_limit = (LW'(r_queue_limit) < LW'(QUEUE_DEPTH)) ? LW'(r_queue_limit)
                                                             : LW'(QUEUE_DEPTH);

    // tail slot = head + count, wrapped once
    assign w_tail_sum = TSW'(r_head) + TSW'(r_count);
    assign w_waddr    = (w_tail_sum >= TSW'(QUEUE_DEPTH))
                        ? AW'(w_tail_sum - TSW'(QUEUE_DEPTH)) : AW'(w_tail_sum);

    assign w_pack = {r_tsum, r_wsum, OCC_W'(r_peak), r_disc, r_acc,
                     OUT_T_W'(r_depart), OUT_T_W'(r_qdelay), OCC_W'(r_occ)};

    // shared unit operand select
    always_comb begin
        w_op = ALU_ADD_TIME;
        w_a  = '0;
        w_b  = '0;
        case (r_state)
            S_ARR: begin
                w_a = UW'(r_arr);
                w_b = UW'(r_gap);
            end
            S_RA: begin
                w_a = UW'(r_arr);
                w_b = UW'(r_source_delay);
            end
            S_RET: begin
                w_op = ALU_SUB;
                w_a  = UW'(r_ra);
                w_b  = UW'(w_rdata);
            end
            S_OCC: begin
                w_op = ALU_SUB;
                w_a  = UW'(r_lastdep);
                w_b  = UW'(r_ra);
            end
            S_DEP: begin
                w_a = UW'(r_depart);
                w_b = UW'(r_service_time);
            end
            S_WS: begin
                w_op = ALU_ADD_SUM;
                w_a  = UW'(r_wsum);
                w_b  = UW'(r_qdelay);
            end
            S_E1: begin
                w_op = ALU_ADD_SUM;
                w_a  = UW'(r_source_delay);
                w_b  = UW'(r_qdelay);
            end
            S_E2: begin
                w_op = ALU_ADD_SUM;
                w_a  = UW'(r_e2e);
                w_b  = UW'(r_service_time);
            end
            S_E3: begin
                w_op = ALU_ADD_SUM;
                w_a  = UW'(r_e2e);
                w_b  = UW'(r_sink_delay);
            end
            S_E4: begin
                w_op = ALU_ADD_SUM;
                w_a  = UW'(r_tsum);
                w_b  = UW'(r_e2e);
            end
            default: begin
                w_op = ALU_ADD_TIME;
            end
        endcase
    end

    // head entry departed at or before router arrival
    assign w_retire = (r_state == S_RET) && (r_count != '0) && !w_borrow;
    assign w_ram_we = (r_state == S_DEP);

    always_comb begin
        n_state     = r_state;
        n_gap       = r_gap;
        n_arr       = r_arr;
        n_ra        = r_ra;
        n_lastdep   = r_lastdep;
        n_head      = r_head;
        n_count     = r_count;
        n_acc       = r_acc;
        n_disc      = r_disc;
        n_peak      = r_peak;
        n_wsum      = r_wsum;
        n_tsum      = r_tsum;
        n_e2e       = r_e2e;
        n_qdelay    = r_qdelay;
        n_depart    = r_depart;
        n_dropped   = r_dropped;
        n_occ       = r_occ;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_drop  = r_out_drop;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_gap = s_axis_tdata;
                    if (s_axis_tuser[0]) begin
                        n_arr     = '0;
                        n_lastdep = '0;
                        n_head    = '0;
                        n_count   = '0;
                        n_acc     = '0;
                        n_disc    = '0;
                        n_peak    = '0;
                        n_wsum    = '0;
                        n_tsum    = '0;
                    end
                    n_state = S_ARR;
                end
            end
            S_ARR: begin
                n_arr   = w_res[TW-1:0];
                n_state = S_RA;
            end
            S_RA: begin
                n_ra    = w_res[TW-1:0];
                n_state = S_RET;
            end
            S_RET: begin
                if (w_retire) begin
                    n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    n_state = S_OCC;
                end
            end
            S_OCC: begin
                n_occ = r_count;
                if (r_count > r_peak) begin
                    n_peak = r_count;
                end
                if (LW'(r_count) >= w_limit) begin
                    n_dropped = 1'b1;
                    n_qdelay  = '0;
                    n_depart  = '0;
                    if (r_disc != '1) begin
                        n_disc = r_disc + 1'b1;
                    end
                    n_state = S_FIN;
                end else begin
                    n_dropped = 1'b0;
                    // service starts at the later of last departure and arrival
                    n_qdelay  = w_borrow ? '0 : w_res[TW-1:0];
                    n_depart  = w_borrow ? r_ra : r_lastdep;
                    n_state   = S_DEP;
                end
            end
            S_DEP: begin
                n_depart  = w_res[TW-1:0];
                n_lastdep = w_res[TW-1:0];
                n_count   = r_count + 1'b1;
                n_state   = S_WS;
            end
            S_WS: begin
                n_wsum  = w_res[SUM_W-1:0];
                n_state = S_E1;
            end
            S_E1: begin
                n_e2e   = w_res[SUM_W-1:0];
                n_state = S_E2;
            end
            S_E2: begin
                n_e2e   = w_res[SUM_W-1:0];
                n_state = S_E3;
            end
            S_E3: begin
                n_e2e   = w_res[SUM_W-1:0];
                n_state = S_E4;
            end
            S_E4: begin
                n_tsum = w_res[SUM_W-1:0];
                if (r_acc != '1) begin
                    n_acc = r_acc + 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_TDATA_W'(w_pack);
                    n_out_drop  = r_dropped;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_delay <= '0;
            r_service_time <= CFG_W'(1);
            r_sink_delay   <= '0;
            r_queue_limit  <= LIMIT_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SOURCE_DELAY: r_source_delay <= i_cfg_data;
                REG_SERVICE_TIME: r_service_time <= i_cfg_data;
                REG_SINK_DELAY:   r_sink_delay   <= i_cfg_data;
                REG_QUEUE_LIMIT:  r_queue_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_arr       <= '0;
            r_lastdep   <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_acc       <= '0;
            r_disc      <= '0;
            r_peak      <= '0;
            r_wsum      <= '0;
            r_tsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_arr       <= n_arr;
            r_lastdep   <= n_lastdep;
            r_head      <= n_head;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_disc      <= n_disc;
            r_peak      <= n_peak;
            r_wsum      <= n_wsum;
            r_tsum      <= n_tsum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap      <= n_gap;
        r_ra       <= n_ra;
        r_e2e      <= n_e2e;
        r_qdelay   <= n_qdelay;
        r_depart   <= n_depart;
        r_dropped  <= n_dropped;
        r_occ      <= n_occ;
        r_out_data <= n_out_data;
        r_out_drop <= n_out_drop;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_drop;

    `DTQ_ASSERT_HOLDS(a_count_bound, r_count <= CW'(QUEUE_DEPTH))
    `DTQ_ASSERT_IMPL(a_drop_no_times, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[102:7] == '0)
    `DTQ_ASSERT_NEXT(a_retire_step, w_retire, r_count == $past(r_count) - 1'b1)
    `DTQ_ASSERT_NEXT(a_push_step, r_state == S_DEP, r_count == $past(r_count) + 1'b1)

endmodule

FILE: test/tb_top.sv
// self-checking testbench for the drop-tail queue timing model
`timescale 1ns / 1ps
module tb_top;
    import dtq_pkg::*;

    localparam logic [63:0] TIME_CAP = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_CAP  = 64'h0FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CNT_CAP  = 64'h0000_0000_FFFF_FFFF;
    localparam int RING_SLOTS     = 64;
    localparam int SEG_ITEMS      = 292;
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic {
        ROW_PACKET,
        ROW_REG_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [31:0]            value;      // gap for a packet, data for a write
        logic                   start;
        bit                     fixed;      // typed-in expectation below applies
        logic                   drop;
        logic [6:0]             occ;
        logic [47:0]            qdelay;
        logic [47:0]            depart;
    } t_stim_row;

    // one result, laid out as {tuser, tdata without padding}
    typedef struct packed {
        logic        dropped;
        logic [59:0] e2e_sum;
        logic [59:0] qdelay_sum;
        logic [6:0]  peak_occ;
        logic [31:0] drop_total;
        logic [31:0] deliv_total;
        logic [47:0] depart;
        logic [47:0] qdelay;
        logic [6:0]  occ;
    } t_pkt_report;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [GAP_W-1:0]       s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    droptail_queue_timing_model u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor copy of registers and queue state
    logic [31:0] src_delay_cfg, svc_time_cfg, sink_delay_cfg;
    logic [6:0]  limit_cfg;
    logic [63:0] arrival_now, last_dep;
    logic [63:0] dep_ring [RING_SLOTS];
    logic [5:0]  ring_head;
    logic [6:0]  ring_fill, occ_peak;
    logic [63:0] n_accepted, n_discarded, qdelay_total, e2e_total;

    t_pkt_report awaited_reports[$];
    t_stim_row   stim_table[$];

    int          n_errors = 0;
    int          n_packets = 0;
    int          n_results = 0;
    int          n_drops_seen = 0;
    int          n_reg_writes = 0;
    int          peak_seen = 0;
    bit          ceiling_seen = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] cap);
        return (a >= cap || b >= cap - a) ? cap : a + b;
    endfunction

    function automatic void clear_queue_state();
        arrival_now  = '0;
        last_dep     = '0;
        ring_head    = '0;
        ring_fill    = '0;
        occ_peak     = '0;
        n_accepted   = '0;
        n_discarded  = '0;
        qdelay_total = '0;
        e2e_total    = '0;
    endfunction

    // advances the queue by one packet and returns what the block should report
    function automatic t_pkt_report route_packet(input logic [31:0] gap, input logic start);
        t_pkt_report rep;
        logic [63:0] router_t, begin_t, dep_t, wait_t, e2e, eff_limit;
        logic [5:0]  tail;
        rep = '0;
        if (start) clear_queue_state();
        arrival_now = sat_add(arrival_now, {32'd0, gap}, TIME_CAP);
        router_t = sat_add(arrival_now, {32'd0, src_delay_cfg}, TIME_CAP);
        while (ring_fill != 0 && dep_ring[ring_head] <= router_t) begin
            ring_head = ring_head + 6'd1;
            ring_fill = ring_fill - 7'd1;
        end
        if (ring_fill > occ_peak) occ_peak = ring_fill;
        eff_limit = (limit_cfg < 7'd64) ? {57'd0, limit_cfg} : 64'd64;
        rep.occ = ring_fill;
        if ({57'd0, ring_fill} >= eff_limit) begin
            rep.dropped = 1'b1;
            n_discarded = sat_add(n_discarded, 64'd1, CNT_CAP);
        end else begin
            begin_t = (last_dep > router_t) ? last_dep : router_t;
            wait_t  = begin_t - router_t;
            dep_t   = sat_add(begin_t, {32'd0, svc_time_cfg}, TIME_CAP);
            tail    = ring_head + ring_fill[5:0];
            dep_ring[tail] = dep_t;
            ring_fill = ring_fill + 7'd1;
            last_dep  = dep_t;
            qdelay_total = sat_add(qdelay_total, wait_t, SUM_CAP);
            e2e = sat_add({32'd0, src_delay_cfg}, wait_t, SUM_CAP);
            e2e = sat_add(e2e, {32'd0, svc_time_cfg}, SUM_CAP);
            e2e = sat_add(e2e, {32'd0, sink_delay_cfg}, SUM_CAP);
            e2e_total  = sat_add(e2e_total, e2e, SUM_CAP);
            n_accepted = sat_add(n_accepted, 64'd1, CNT_CAP);
            rep.qdelay = wait_t[47:0];
            rep.depart = dep_t[47:0];
        end
        rep.deliv_total = n_accepted[31:0];
        rep.drop_total  = n_discarded[31:0];
        rep.peak_occ    = occ_peak;
        rep.qdelay_sum  = qdelay_total[59:0];
        rep.e2e_sum     = e2e_total[59:0];
        return rep;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        case (idx)
            REG_SOURCE_DELAY: src_delay_cfg  = val;
            REG_SERVICE_TIME: svc_time_cfg   = val;
            REG_SINK_DELAY:   sink_delay_cfg = val;
            REG_QUEUE_LIMIT:  limit_cfg      = val[6:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] pick_gap(input logic [31:0] span);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return '0;
        if (roll < 10) return $urandom();
        if (roll < 13) return '1;
        return $urandom_range(0, span);
    endfunction

    task automatic row_pkt(input logic [31:0] gap, input logic start);
        t_stim_row r;
        r = '{kind: ROW_PACKET, default: '0};
        r.value = gap;
        r.start = start;
        stim_table.push_back(r);
    endtask

    task automatic row_pkt_known(input logic [31:0] gap, input logic start, input logic drop,
                                 input logic [6:0] occ, input logic [47:0] qd,
                                 input logic [47:0] dep);
        t_stim_row r;
        r = '{kind: ROW_PACKET, default: '0};
        r.value  = gap;
        r.start  = start;
        r.fixed  = 1'b1;
        r.drop   = drop;
        r.occ    = occ;
        r.qdelay = qd;
        r.depart = dep;
        stim_table.push_back(r);
    endtask

    task automatic row_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        t_stim_row r;
        r = '{kind: ROW_REG_WRITE, default: '0};
        r.reg_idx = idx;
        r.value   = val;
        stim_table.push_back(r);
    endtask

    task automatic send_packet(input t_stim_row r);
        t_pkt_report rep;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.value;
        s_axis_tuser  <= r.start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // transaction taken at this edge
        rep = route_packet(r.value, r.start);
        if (r.fixed) begin
            rep.dropped = r.drop;
            rep.occ     = r.occ;
            rep.qdelay  = r.qdelay;
            rep.depart  = r.depart;
        end
        awaited_reports.push_back(rep);
        n_packets++;
    endtask

    // hold the sender until every result is back and the block has gone quiet
    task automatic settle_queue();
        s_axis_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
        n_reg_writes++;
    endtask

    task automatic set_config(input logic [31:0] src, input logic [31:0] svc,
                              input logic [31:0] snk, input logic [31:0] lim);
        settle_queue();
        write_reg(REG_SOURCE_DELAY, src);
        write_reg(REG_SERVICE_TIME, svc);
        write_reg(REG_SINK_DELAY, snk);
        write_reg(REG_QUEUE_LIMIT, lim);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_report(input t_pkt_report want, input t_pkt_report got);
        check_field("was_dropped", 64'(want.dropped), 64'(got.dropped));
        check_field("occupancy_seen", 64'(want.occ), 64'(got.occ));
        check_field("queue_delay", 64'(want.qdelay), 64'(got.qdelay));
        check_field("depart_time", 64'(want.depart), 64'(got.depart));
        check_field("delivered_total", 64'(want.deliv_total), 64'(got.deliv_total));
        check_field("dropped_total", 64'(want.drop_total), 64'(got.drop_total));
        check_field("peak_occupancy", 64'(want.peak_occ), 64'(got.peak_occ));
        check_field("queue_delay_sum", 64'(want.qdelay_sum), 64'(got.qdelay_sum));
        check_field("end_to_end_sum", 64'(want.e2e_sum), 64'(got.e2e_sum));
    endtask

    // result side: random backpressure and checking
    initial begin
        t_pkt_report want, got;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata[OUT_PACK_W-1:0]};
                n_results++;
                if (got.dropped) n_drops_seen++;
                if (got.occ > peak_seen) peak_seen = got.occ;
                if (got.depart == TIME_CAP[47:0]) ceiling_seen = 1'b1;
                if (m_axis_tdata[OUT_TDATA_W-1:OUT_PACK_W] != '0) begin
                    n_errors++;
                    $display("%0t: tdata padding mismatch, expected 0, actual %0d", $time,
                             m_axis_tdata[OUT_TDATA_W-1:OUT_PACK_W]);
                end
                if (awaited_reports.size() == 0) begin
                    n_errors++;
                    $display("%0t: result with none outstanding, expected nothing, actual %h",
                             $time, got);
                end else begin
                    want = awaited_reports.pop_front();
                    compare_report(want, got);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 WATCHDOG_LIMIT, awaited_reports.size());
        $display("droptail_queue_timing_model regression: fail");
        $finish;
    end

    initial begin
        t_stim_row   row;
        logic [31:0] span;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_SOURCE_DELAY;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        src_delay_cfg  = 32'd0;
        svc_time_cfg   = 32'd1;
        sink_delay_cfg = 32'd0;
        limit_cfg      = 7'd64;
        clear_queue_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults, retirement, start flag, zero and small limits,
        // limit above the ring depth, gap and register extremes
        row_pkt_known(32'd0, 1'b0, 1'b0, 7'd0, 48'd0, 48'd1);
        row_pkt_known(32'd0, 1'b0, 1'b0, 7'd1, 48'd1, 48'd2);
        row_pkt_known(32'd5, 1'b0, 1'b0, 7'd0, 48'd0, 48'd6);
        row_pkt(32'hFFFF_FFFF, 1'b0);
        row_pkt_known(32'd0, 1'b1, 1'b0, 7'd0, 48'd0, 48'd1);
        row_reg(REG_QUEUE_LIMIT, 32'd0);
        row_pkt_known(32'd3, 1'b0, 1'b1, 7'd0, 48'd0, 48'd0);
        row_pkt_known(32'd0, 1'b1, 1'b1, 7'd0, 48'd0, 48'd0);
        row_reg(REG_SERVICE_TIME, 32'd1000);
        row_reg(REG_SOURCE_DELAY, 32'd7);
        row_reg(REG_SINK_DELAY, 32'd9);
        row_reg(REG_QUEUE_LIMIT, 32'd2);
        row_pkt_known(32'd0, 1'b1, 1'b0, 7'd0, 48'd0, 48'd1007);
        row_pkt_known(32'd0, 1'b0, 1'b0, 7'd1, 48'd1000, 48'd2007);
        row_pkt_known(32'd0, 1'b0, 1'b1, 7'd2, 48'd0, 48'd0);
        row_pkt(32'd1000, 1'b0);
        // only the low seven bits land in the limit register: 100
        row_reg(REG_QUEUE_LIMIT, 32'hFFFF_FFE4);
        row_pkt(32'hAAAA_AAAA, 1'b0);
        row_pkt(32'h5555_5555, 1'b0);
        row_reg(REG_SERVICE_TIME, 32'd0);
        row_pkt(32'd0, 1'b0);
        row_reg(REG_SERVICE_TIME, 32'hFFFF_FFFF);
        row_pkt(32'd0, 1'b0);
        row_pkt(32'd0, 1'b0);

        src_idle_pct = 11;
        snk_idle_pct = 82;
        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_REG_WRITE) begin
                settle_queue();
                write_reg(stim_table[i].reg_idx, stim_table[i].value);
                i_cfg_we <= 1'b0;
            end else begin
                send_packet(stim_table[i]);
            end
        end

        // random segments, each with its own register setting
        for (int seg = 0; seg < 6; seg++) begin
            src_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 82 : 0;
            snk_idle_pct = (seg < 2) ? 82 : (seg < 4) ? 11 : 0;
            case (seg)
                0: begin
                    set_config($urandom_range(0, 50), $urandom_range(1, 200),
                               $urandom_range(0, 50), $urandom_range(1, 16));
                    span = 2 * svc_time_cfg;
                end
                1: begin
                    // arrivals outpace service so the ring runs full
                    set_config(32'd0, 32'd1000, 32'd0, 32'd64);
                    span = svc_time_cfg;
                end
                2: begin
                    set_config($urandom(), $urandom_range(1, 5000), $urandom(), 32'd100);
                    span = svc_time_cfg;
                end
                3: begin
                    set_config($urandom_range(0, 1000), 32'd300, $urandom_range(0, 1000), 32'd1);
                    span = 2 * svc_time_cfg;
                end
                4: begin
                    set_config($urandom_range(0, 100), 32'd0, $urandom_range(0, 100),
                               $urandom_range(0, 64));
                    span = 32'd100;
                end
                default: begin
                    set_config('1, '1, '1, 32'd64);
                    span = '1;
                end
            endcase
            for (int k = 0; k < SEG_ITEMS; k++) begin
                if ($urandom_range(0, 99) == 0) settle_queue();
                row = '{kind: ROW_PACKET, default: '0};
                row.value = pick_gap(span);
                row.start = (seg == 0 && k == 0) || ($urandom_range(0, 49) == 0);
                send_packet(row);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("summary: %0d packets in, %0d results checked, %0d drops, %0d register writes",
                 n_packets, n_results, n_drops_seen, n_reg_writes);
        $display("summary: deepest queue %0d, departure ceiling reached %0d, %0d mismatches",
                 peak_seen, ceiling_seen, n_errors);
        if (n_errors == 0) begin
            $display("droptail_queue_timing_model regression: pass");
        end else begin
            $display("droptail_queue_timing_model regression: fail");
        end
        $finish;
    end

endmodule
